/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge of clk while reset is released.
`define GFSTB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checked on every rising edge of clk, reset included.
`define GFSTB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define GFSTB_ASSERT(lbl, prop, msg)
`define GFSTB_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* src/gfstb_pkg.sv */
`timescale 1ns / 1ps

package gfstb_pkg;

	localparam int MAX_FIELD_BITS = 4;
	localparam int ELEM_W         = 4;
	localparam int NUM_ELEMS      = 7;
	localparam int PROD_W         = 2 * ELEM_W;
	localparam int NSTG           = 4;
	localparam int FB_W           = 3;
	localparam int POLY_W         = 5;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 5;

	localparam logic [FB_W-1:0]   FIELD_BITS_RST = 3'd4;
	localparam logic [POLY_W-1:0] POLY_RST       = 5'd19;
	localparam logic [ELEM_W-1:0] GF_ONE         = 4'd1;

	typedef logic [ELEM_W-1:0] elem_t;
	typedef logic [NUM_ELEMS-1:0][ELEM_W-1:0] tuple_t;

	typedef enum logic {
		OP_FORWARD,
		OP_INVERSE
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIELD_BITS,
		CFG_REDUCTION_POLY
	} cfg_reg_t;

	// Effective field: degree, element mask and the low bits of the modulus.
	typedef struct packed {
		logic [FB_W-1:0] k;
		elem_t           mask;
		elem_t           poly;
	} fld_t;

	typedef struct packed {
		logic [NSTG-1:0] en;
		logic [NSTG-1:0] vld;
	} ctl_t;

	// Carry-less product reduced modulo x^k + poly.
	function automatic elem_t fmul(fld_t f, elem_t a, elem_t b);
		logic [PROD_W-1:0] r;
		elem_t am;
		elem_t bm;
		logic [FB_W-1:0] sh;
		begin
			am = a & f.mask;
			bm = b & f.mask;
			r = '0;
			for (int i = 0; i < ELEM_W; i++) begin
				if (bm[i]) r = r ^ ({{(PROD_W-ELEM_W){1'b0}}, am} << i);
			end
			for (int j = PROD_W - 2; j >= 0; j--) begin
				sh = FB_W'(j) - f.k;
				if ((FB_W'(j) >= f.k) && r[j]) begin
					r = r ^ ((PROD_W'(f.poly) << sh) | (PROD_W'(1) << j));
				end
			end
			return r[ELEM_W-1:0] & f.mask;
		end
	endfunction

	function automatic elem_t fsq(fld_t f, elem_t a);
		return fmul(f, a, a);
	endfunction

	// Square root in GF(2^k) is k-1 repeated squarings.
	function automatic elem_t froot(fld_t f, elem_t a);
		elem_t x;
		begin
			x = a & f.mask;
			for (int i = 1; i < MAX_FIELD_BITS; i++) begin
				if (FB_W'(i) < f.k) x = fsq(f, x);
			end
			return x;
		end
	endfunction

endpackage

/* src/gfstb_req_if.sv */
`timescale 1ns / 1ps

interface gfstb_req_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [gfstb_pkg::ELEM_W-1:0] in_e0;
	logic [gfstb_pkg::ELEM_W-1:0] in_e1;
	logic [gfstb_pkg::ELEM_W-1:0] in_e2;
	logic [gfstb_pkg::ELEM_W-1:0] in_e3;
	logic [gfstb_pkg::ELEM_W-1:0] in_e4;
	logic [gfstb_pkg::ELEM_W-1:0] in_e5;
	logic [gfstb_pkg::ELEM_W-1:0] in_e6;

	modport source(output valid, op, in_e0, in_e1, in_e2, in_e3, in_e4, in_e5, in_e6,
		input ready);
	modport sink(input valid, op, in_e0, in_e1, in_e2, in_e3, in_e4, in_e5, in_e6,
		output ready);
endinterface

/* src/gfstb_rsp_if.sv */
`timescale 1ns / 1ps

interface gfstb_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [gfstb_pkg::ELEM_W-1:0] out_e0;
	logic [gfstb_pkg::ELEM_W-1:0] out_e1;
	logic [gfstb_pkg::ELEM_W-1:0] out_e2;
	logic [gfstb_pkg::ELEM_W-1:0] out_e3;
	logic [gfstb_pkg::ELEM_W-1:0] out_e4;
	logic [gfstb_pkg::ELEM_W-1:0] out_e5;
	logic [gfstb_pkg::ELEM_W-1:0] out_e6;

	modport source(output valid, out_e0, out_e1, out_e2, out_e3, out_e4, out_e5, out_e6,
		input ready);
	modport sink(input valid, out_e0, out_e1, out_e2, out_e3, out_e4, out_e5, out_e6,
		output ready);
endinterface

/* src/gfstb_cfg_if.sv */
`timescale 1ns / 1ps

interface gfstb_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [gfstb_pkg::CFG_IDX_W-1:0]   index;
	logic [gfstb_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* src/gf_seven_tuple_bijection.sv */
`timescale 1ns / 1ps
// Maps a seven-tuple over GF(2^K) to seven polynomial coefficients (op = 0)
// or back again (op = 1).
// Channels: req carries op and in_e0..in_e6, rsp carries out_e0..out_e6, both
// valid/ready; a request is taken at an edge where valid and ready are high.
// cfg writes field_bits (index 0) or reduction_poly (index 1); it is always
// ready, and should only be written while no request is in flight.
// rsp.valid rises once the request has passed through the register stages; there
// are four register stages and a new request can enter every cycle unless all
// four hold a request and rsp.ready is low.
// Input elements are masked to K bits; results are always below 2^K.
// Reset empties the pipeline and sets K = 4 with modulus x^4 + x + 1.
// When rsp.ready is low, results stay put and the stages behind them fill;
// req.ready drops only once all four stages hold a request.
`include "assert_macros.svh"

module gf_seven_tuple_bijection (
	input  logic         clk,
	input  logic         arst_n,
	gfstb_req_if.sink    req,
	gfstb_rsp_if.source  rsp,
	gfstb_cfg_if.sink    cfg
);

	logic [gfstb_pkg::FB_W-1:0]   fb_q;
	logic [gfstb_pkg::POLY_W-1:0] poly_q;
	gfstb_pkg::fld_t              fld;
	gfstb_pkg::ctl_t              ctl;
	gfstb_pkg::tuple_t            tup;
	gfstb_pkg::tuple_t            fwd_res;
	gfstb_pkg::tuple_t            inv_res;
	gfstb_pkg::tuple_t            res_s4;
	logic                         op_s1, op_s2, op_s3;
	gfstb_pkg::elem_t             res_any;
	logic                         out_stall;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q   <= gfstb_pkg::FIELD_BITS_RST;
			poly_q <= gfstb_pkg::POLY_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				gfstb_pkg::CFG_FIELD_BITS: begin
					fb_q <= cfg.data[gfstb_pkg::FB_W-1:0];
				end
				gfstb_pkg::CFG_REDUCTION_POLY: begin
					poly_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	// A degree of zero acts as one; larger than the maximum saturates.
	always_comb begin
		if (fb_q == '0) begin
			fld.k = gfstb_pkg::FB_W'(1);
		end else if (fb_q > gfstb_pkg::FB_W'(gfstb_pkg::MAX_FIELD_BITS)) begin
			fld.k = gfstb_pkg::FB_W'(gfstb_pkg::MAX_FIELD_BITS);
		end else begin
			fld.k = fb_q;
		end
		fld.mask = gfstb_pkg::ELEM_W'((5'd1 << fld.k) - 5'd1);
		fld.poly = poly_q[gfstb_pkg::ELEM_W-1:0] & fld.mask;
	end

	assign tup[0] = req.in_e0 & fld.mask;
	assign tup[1] = req.in_e1 & fld.mask;
	assign tup[2] = req.in_e2 & fld.mask;
	assign tup[3] = req.in_e3 & fld.mask;
	assign tup[4] = req.in_e4 & fld.mask;
	assign tup[5] = req.in_e5 & fld.mask;
	assign tup[6] = req.in_e6 & fld.mask;

	gfstb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl)
	);

	gfstb_fwd u_fwd (
		.clk (clk),
		.ctl (ctl),
		.fld (fld),
		.tup (tup),
		.res (fwd_res)
	);

	gfstb_inv u_inv (
		.clk (clk),
		.ctl (ctl),
		.fld (fld),
		.tup (tup),
		.res (inv_res)
	);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) op_s1 <= req.op;
		if (ctl.en[1]) op_s2 <= op_s1;
		if (ctl.en[2]) op_s3 <= op_s2;
		if (ctl.en[3]) begin
			res_s4 <= (op_s3 == gfstb_pkg::OP_INVERSE) ? inv_res : fwd_res;
		end
	end

	assign req.ready  = ctl.en[0];
	assign rsp.valid  = ctl.vld[gfstb_pkg::NSTG-1];
	assign rsp.out_e0 = res_s4[0];
	assign rsp.out_e1 = res_s4[1];
	assign rsp.out_e2 = res_s4[2];
	assign rsp.out_e3 = res_s4[3];
	assign rsp.out_e4 = res_s4[4];
	assign rsp.out_e5 = res_s4[5];
	assign rsp.out_e6 = res_s4[6];

	assign res_any = res_s4[0] | res_s4[1] | res_s4[2] | res_s4[3] | res_s4[4] | res_s4[5]
		| res_s4[6];
	assign out_stall = ctl.vld[2] && !ctl.en[3];

	`GFSTB_ASSERT(a_result_in_field, rsp.valid |-> ((res_any & ~fld.mask) == '0), "result too wide")
	`GFSTB_ASSERT(a_backpressure_full, !req.ready |-> (&ctl.vld), "request refused, stage free")
	`GFSTB_ASSERT(a_stall_keeps_items, out_stall |=> (ctl.vld[2] && ctl.vld[3]), "request lost")

endmodule

/* src/gfstb_ctrl.sv */
`timescale 1ns / 1ps

module gfstb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_ready,
	output gfstb_pkg::ctl_t   ctl
);

	logic [gfstb_pkg::NSTG-1:0] vld_q;
	logic [gfstb_pkg::NSTG-1:0] rdy;

	// A stage can load when it is empty or its content moves on this cycle.
	always_comb begin
		rdy[gfstb_pkg::NSTG-1] = !vld_q[gfstb_pkg::NSTG-1] || out_ready;
		for (int i = gfstb_pkg::NSTG - 2; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= in_valid;
			for (int i = 1; i < gfstb_pkg::NSTG; i++) begin
				if (rdy[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign ctl.en  = rdy;
	assign ctl.vld = vld_q;

endmodule

/* src/gfstb_fwd.sv */
`timescale 1ns / 1ps

module gfstb_fwd (
	input  logic               clk,
	input  gfstb_pkg::ctl_t    ctl,
	input  gfstb_pkg::fld_t    fld,
	input  gfstb_pkg::tuple_t  tup,
	output gfstb_pkg::tuple_t  res
);

	gfstb_pkg::tuple_t c_s1;
	gfstb_pkg::elem_t  b_s1, e_s1, d_s1;

	gfstb_pkg::elem_t  c3_s2, c4_s2, c6_s2, bsq_s2, t3_s2, sx2_s2, sx1_s2;

	gfstb_pkg::tuple_t g_s3;

	// Stage 1: first products of the tuple.
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			c_s1 <= tup;
			b_s1 <= tup[0] ^ tup[1];
			e_s1 <= tup[2] ^ gfstb_pkg::fmul(fld, tup[0], tup[1]);
			d_s1 <= gfstb_pkg::fmul(fld, tup[1], tup[2]);
		end
	end

	// Stage 2: squares and the terms that are later scaled by c4.
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			c3_s2  <= c_s1[3];
			c4_s2  <= c_s1[4];
			c6_s2  <= c_s1[6];
			bsq_s2 <= gfstb_pkg::fsq(fld, b_s1);
			t3_s2  <= gfstb_pkg::fsq(fld, e_s1) ^ gfstb_pkg::fmul(fld, c_s1[3], b_s1)
				^ gfstb_pkg::GF_ONE;
			sx2_s2 <= gfstb_pkg::fmul(fld, c_s1[3], e_s1) ^ c_s1[0];
			sx1_s2 <= gfstb_pkg::fsq(fld, d_s1) ^ gfstb_pkg::fmul(fld, c_s1[3], d_s1)
				^ c_s1[5];
		end
	end

	// Stage 3: coefficients.
	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			g_s3[6] <= c4_s2;
			g_s3[5] <= bsq_s2;
			g_s3[4] <= c3_s2 ^ gfstb_pkg::fmul(fld, c4_s2, bsq_s2);
			g_s3[3] <= t3_s2 ^ gfstb_pkg::fmul(fld, c3_s2, c4_s2);
			g_s3[2] <= sx2_s2 ^ gfstb_pkg::fmul(fld, c4_s2, t3_s2);
			g_s3[1] <= sx1_s2 ^ gfstb_pkg::fmul(fld, c4_s2, sx2_s2);
			g_s3[0] <= c6_s2 ^ gfstb_pkg::fmul(fld, c4_s2, sx1_s2);
		end
	end

	assign res = g_s3;

endmodule

/* src/gfstb_inv.sv */
`timescale 1ns / 1ps

module gfstb_inv (
	input  logic               clk,
	input  gfstb_pkg::ctl_t    ctl,
	input  gfstb_pkg::fld_t    fld,
	input  gfstb_pkg::tuple_t  tup,
	output gfstb_pkg::tuple_t  res
);

	gfstb_pkg::tuple_t g_s1;
	gfstb_pkg::elem_t  p1_s1, p2_s1;

	gfstb_pkg::elem_t  g0_s2, g1_s2, g2_s2, p0_s2, p1_s2, p2_s2, p3_s2, m21_s2;

	gfstb_pkg::elem_t  g0_s3, g1_s3, p0_s3, p1_s3, p2_s3, p4_s3, w_s3, m23_s3;

	gfstb_pkg::elem_t  p1_in, p3_in, m21_in, m23_in, p4_in;
	gfstb_pkg::elem_t  d, sd, pd, p5, p6;

	// Stage 1: root of the X^5 coefficient, then p2.
	always_comb begin
		p1_in = gfstb_pkg::froot(fld, tup[5]);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			g_s1  <= tup;
			p1_s1 <= p1_in;
			p2_s1 <= tup[4] ^ gfstb_pkg::fmul(fld, tup[6], gfstb_pkg::fsq(fld, p1_in));
		end
	end

	// Stage 2: p3 is a root taken over a sum of products.
	always_comb begin
		m21_in = gfstb_pkg::fmul(fld, p2_s1, p1_s1);
		p3_in  = gfstb_pkg::froot(fld, g_s1[3] ^ m21_in ^ gfstb_pkg::GF_ONE
			^ gfstb_pkg::fmul(fld, p2_s1, g_s1[6]));
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			g0_s2  <= g_s1[0];
			g1_s2  <= g_s1[1];
			g2_s2  <= g_s1[2];
			p0_s2  <= g_s1[6];
			p1_s2  <= p1_s1;
			p2_s2  <= p2_s1;
			p3_s2  <= p3_in;
			m21_s2 <= m21_in;
		end
	end

	// Stage 3: p4 and w.
	always_comb begin
		m23_in = gfstb_pkg::fmul(fld, p2_s2, p3_s2);
		p4_in  = g2_s2 ^ m23_in ^ p1_s2 ^ gfstb_pkg::fmul(fld, p0_s2,
			gfstb_pkg::fsq(fld, p3_s2) ^ m21_s2 ^ gfstb_pkg::GF_ONE);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			g0_s3  <= g0_s2;
			g1_s3  <= g1_s2;
			p0_s3  <= p0_s2;
			p1_s3  <= p1_s2;
			p2_s3  <= p2_s2;
			p4_s3  <= p4_in;
			m23_s3 <= m23_in;
			w_s3   <= p3_s2 ^ gfstb_pkg::fmul(fld, p1_s2, p4_in) ^ gfstb_pkg::fsq(fld, p4_in);
		end
	end

	// Last stage is combinational here; the output register sits in the top level.
	always_comb begin
		d  = gfstb_pkg::fmul(fld, p4_s3, w_s3);
		sd = gfstb_pkg::fsq(fld, d);
		pd = gfstb_pkg::fmul(fld, p2_s3, d);
		p5 = g1_s3 ^ sd ^ pd ^ gfstb_pkg::fmul(fld, p0_s3, m23_s3 ^ p1_s3 ^ p4_s3);
		p6 = g0_s3 ^ gfstb_pkg::fmul(fld, p0_s3, sd ^ pd ^ p5);
	end

	assign res[0] = p1_s3 ^ p4_s3;
	assign res[1] = p4_s3;
	assign res[2] = w_s3;
	assign res[3] = p2_s3;
	assign res[4] = p0_s3;
	assign res[5] = p5;
	assign res[6] = p6;

endmodule

/* tb/gf_seven_tuple_bijection_tb.sv */
`timescale 1ns / 1ps

module gf_seven_tuple_bijection_tb;
	import gfstb_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 10;
	localparam int ITEMS_PER_SET  = 100;
	localparam int PIPE_LATENCY   = 4;
	localparam int DRAIN_SLACK    = 2 * PIPE_LATENCY;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int NUM_FIXED_SETS = 13;
	localparam int NUM_RAND_SETS  = 3;

	typedef enum int {
		RX_OPEN,
		RX_MOSTLY,
		RX_SPARSE,
		RX_PERIODIC,
		RX_BLOCKED
	} rx_mode_t;

	// Field settings visited after the reset setting: primitive and reducible
	// moduli, field widths at both ends and beyond them, stray high bits.
	int set_field_bits[NUM_FIXED_SETS] = '{4, 4, 3, 3, 2, 1, 0, 7, 5, 6, 4, 2, 3};
	int set_modulus[NUM_FIXED_SETS]    = '{25, 31, 11, 13, 7, 3, 30, 19, 9, 0, 16, 5, 27};

	class tuple_scoreboard;
		logic [FB_W-1:0]   field_bits;
		logic [POLY_W-1:0] reduction_poly;
		int                deg;
		elem_t             emask;
		logic [POLY_W-1:0] modulus;
		tuple_t            expected_q[$];
		int unsigned       mismatches;
		int unsigned       matched;

		function new();
			field_bits = FIELD_BITS_RST;
			reduction_poly = POLY_RST;
			mismatches = 0;
			matched = 0;
			derive_field();
		endfunction

		function void derive_field();
			deg = int'(field_bits);
			if (deg == 0) deg = 1;
			if (deg > MAX_FIELD_BITS) deg = MAX_FIELD_BITS;
			emask = elem_t'((1 << deg) - 1);
			modulus = (reduction_poly & POLY_W'(emask)) | (POLY_W'(1) << deg);
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_FIELD_BITS: field_bits = value[FB_W-1:0];
				CFG_REDUCTION_POLY: reduction_poly = value[POLY_W-1:0];
				default: ;
			endcase
			derive_field();
		endfunction

		function elem_t gf_mul(elem_t a, elem_t b);
			logic [PROD_W-1:0] acc;
			elem_t am;
			elem_t bm;
			am = a & emask;
			bm = b & emask;
			acc = '0;
			for (int i = 0; i < deg; i++)
				if (bm[i]) acc = acc ^ (PROD_W'(am) << i);
			for (int bitpos = 2 * deg - 1; bitpos >= deg; bitpos--)
				if (acc[bitpos]) acc = acc ^ (PROD_W'(modulus) << (bitpos - deg));
			return acc[ELEM_W-1:0] & emask;
		endfunction

		function elem_t gf_sq(elem_t a);
			return gf_mul(a, a);
		endfunction

		function elem_t gf_root(elem_t a);
			elem_t x;
			x = a & emask;
			for (int i = 1; i < deg; i++) x = gf_sq(x);
			return x;
		endfunction

		function tuple_t mask_tuple(tuple_t t);
			tuple_t m;
			for (int i = 0; i < NUM_ELEMS; i++) m[i] = t[i] & emask;
			return m;
		endfunction

		function tuple_t map_forward(tuple_t c);
			elem_t b, e, d, bsq, cb, esq, dsq, t3, s2, s1;
			tuple_t g;
			b = c[0] ^ c[1];
			e = c[2] ^ gf_mul(c[0], c[1]);
			d = gf_mul(c[1], c[2]);
			bsq = gf_sq(b);
			cb = gf_mul(c[3], b);
			esq = gf_sq(e);
			dsq = gf_sq(d);
			t3 = esq ^ cb ^ GF_ONE;
			s2 = gf_mul(c[3], e) ^ c[0];
			s1 = dsq ^ gf_mul(c[3], d) ^ c[5];
			g[6] = c[4];
			g[5] = bsq;
			g[4] = c[3] ^ gf_mul(c[4], bsq);
			g[3] = t3 ^ gf_mul(c[3], c[4]);
			g[2] = s2 ^ gf_mul(c[4], t3);
			g[1] = s1 ^ gf_mul(c[4], s2);
			g[0] = c[6] ^ gf_mul(c[4], s1);
			return mask_tuple(g);
		endfunction

		function tuple_t map_inverse(tuple_t g);
			elem_t p0, p1, p2, p3, p4, p5, p6, w, d;
			tuple_t c;
			p0 = g[6];
			p1 = gf_root(g[5]);
			p2 = g[4] ^ gf_mul(p0, gf_sq(p1));
			p3 = gf_root(g[3] ^ gf_mul(p2, p1) ^ GF_ONE ^ gf_mul(p2, p0));
			p4 = g[2] ^ gf_mul(p2, p3) ^ p1
				^ gf_mul(p0, gf_sq(p3) ^ gf_mul(p2, p1) ^ GF_ONE);
			w = p3 ^ gf_mul(p1, p4) ^ gf_sq(p4);
			d = gf_mul(p4, w);
			p5 = g[1] ^ gf_sq(d) ^ gf_mul(p2, d) ^ gf_mul(p0, gf_mul(p2, p3) ^ p1 ^ p4);
			p6 = g[0] ^ gf_mul(p0, gf_sq(d) ^ gf_mul(p2, d) ^ p5);
			c[0] = p1 ^ p4;
			c[1] = p4;
			c[2] = w;
			c[3] = p2;
			c[4] = p0;
			c[5] = p5;
			c[6] = p6;
			return mask_tuple(c);
		endfunction

		function void note_request(op_t op, tuple_t raw);
			if (op == OP_INVERSE) expected_q.push_back(map_inverse(mask_tuple(raw)));
			else expected_q.push_back(map_forward(mask_tuple(raw)));
		endfunction

		function void check_result(tuple_t got);
			tuple_t want;
			bit bad;
			if (expected_q.size() == 0) begin
				$display("%0t: result with no request outstanding, got %h", $time, got);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			bad = 1'b0;
			for (int i = 0; i < NUM_ELEMS; i++) begin
				if (got[i] !== want[i]) begin
					$display("%0t: out_e%0d expected %h actual %h", $time, i, want[i], got[i]);
					bad = 1'b1;
				end
			end
			if (bad) mismatches++;
			else matched++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	gfstb_req_if req_ch();
	gfstb_rsp_if rsp_ch();
	gfstb_cfg_if cfg_ch();

	gf_seven_tuple_bijection dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	tuple_scoreboard sb;
	int unsigned n_forward;
	int unsigned n_inverse;
	int unsigned n_settings;
	int unsigned idle_cycles;

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		tuple_t sent;
		tuple_t got;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
			if (req_ch.valid && req_ch.ready) begin
				sent[0] = req_ch.in_e0;
				sent[1] = req_ch.in_e1;
				sent[2] = req_ch.in_e2;
				sent[3] = req_ch.in_e3;
				sent[4] = req_ch.in_e4;
				sent[5] = req_ch.in_e5;
				sent[6] = req_ch.in_e6;
				sb.note_request(op_t'(req_ch.op), sent);
				if (req_ch.op == OP_INVERSE) n_inverse++;
				else n_forward++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got[0] = rsp_ch.out_e0;
				got[1] = rsp_ch.out_e1;
				got[2] = rsp_ch.out_e2;
				got[3] = rsp_ch.out_e3;
				got[4] = rsp_ch.out_e4;
				got[5] = rsp_ch.out_e5;
				got[6] = rsp_ch.out_e6;
				sb.check_result(got);
			end
		end
	end

	// Any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// The receiver switches between stall patterns of random length.
	initial begin
		rx_mode_t mode;
		int span;
		int phase;
		rsp_ch.ready = 1'b0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 4));
			span = (mode == RX_BLOCKED) ? $urandom_range(1, 40) : $urandom_range(20, 150);
			phase = 0;
			repeat (span) begin
				@(negedge clk);
				case (mode)
					RX_OPEN: rsp_ch.ready <= 1'b1;
					RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: rsp_ch.ready <= ((phase % 7) < 4);
					default: rsp_ch.ready <= 1'b0;
				endcase
				phase++;
			end
		end
	end

	task automatic send_request(op_t op, tuple_t t);
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.in_e0 <= t[0];
		req_ch.in_e1 <= t[1];
		req_ch.in_e2 <= t[2];
		req_ch.in_e3 <= t[3];
		req_ch.in_e4 <= t[4];
		req_ch.in_e5 <= t[5];
		req_ch.in_e6 <= t[6];
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Idle cycles on the request side carry junk payload.
	task automatic idle_gap(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			req_ch.op <= 1'($urandom_range(0, 1));
			req_ch.in_e0 <= ELEM_W'($urandom_range(0, 15));
			req_ch.in_e3 <= ELEM_W'($urandom_range(0, 15));
			req_ch.in_e6 <= ELEM_W'($urandom_range(0, 15));
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// The upper data bits of a field width write are junk the register drops.
	task automatic set_field(int fb, int poly);
		logic [CFG_DATA_W-1:0] fb_word;
		fb_word = CFG_DATA_W'($urandom_range(0, 3) << FB_W) | CFG_DATA_W'(fb);
		wait_drained();
		write_cfg(CFG_FIELD_BITS, fb_word);
		write_cfg(CFG_REDUCTION_POLY, CFG_DATA_W'(poly));
		n_settings++;
	endtask

	task automatic run_directed();
		tuple_t t;
		send_request(OP_FORWARD, '0);
		send_request(OP_INVERSE, '0);
		send_request(OP_FORWARD, '1);
		send_request(OP_INVERSE, '1);
		for (int i = 0; i < NUM_ELEMS; i++) t[i] = GF_ONE;
		send_request(OP_FORWARD, t);
		send_request(OP_INVERSE, t);
		for (int p = 0; p < NUM_ELEMS; p++) begin
			t = '0;
			t[p] = '1;
			send_request(OP_FORWARD, t);
			send_request(OP_INVERSE, t);
		end
	endtask

	// A third of the inverse requests take a forward image, with stray high
	// bits added so the input masking is exercised on realistic data.
	task automatic random_item(output op_t op, output tuple_t t);
		int pick;
		for (int i = 0; i < NUM_ELEMS; i++) t[i] = elem_t'($urandom_range(0, 15));
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			op = OP_FORWARD;
		end else if (pick < 8) begin
			op = OP_INVERSE;
		end else begin
			op = OP_INVERSE;
			t = sb.map_forward(sb.mask_tuple(t));
			for (int i = 0; i < NUM_ELEMS; i++)
				t[i] = t[i] | (elem_t'($urandom_range(0, 15)) & ~sb.emask);
		end
	endtask

	task automatic run_random(int n_items);
		int sent;
		int burst;
		int pause_at;
		op_t op;
		tuple_t t;
		sent = 0;
		burst = $urandom_range(1, 24);
		pause_at = $urandom_range(n_items / 4, 3 * n_items / 4);
		while (sent < n_items) begin
			if (sent == pause_at) wait_drained();
			if (burst == 0) begin
				idle_gap($urandom_range(1, 12));
				burst = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 24);
			end
			random_item(op, t);
			send_request(op, t);
			sent++;
			burst--;
		end
		idle_gap(1);
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_FORWARD;
		req_ch.in_e0 = '0;
		req_ch.in_e1 = '0;
		req_ch.in_e2 = '0;
		req_ch.in_e3 = '0;
		req_ch.in_e4 = '0;
		req_ch.in_e5 = '0;
		req_ch.in_e6 = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_FIELD_BITS;
		cfg_ch.data = '0;
		n_forward = 0;
		n_inverse = 0;
		n_settings = 1;
		idle_cycles = 0;
		sb = new();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		run_random(ITEMS_PER_SET);
		for (int s = 0; s < NUM_FIXED_SETS; s++) begin
			set_field(set_field_bits[s], set_modulus[s]);
			run_directed();
			run_random(ITEMS_PER_SET);
		end
		repeat (NUM_RAND_SETS) begin
			set_field($urandom_range(0, 7), $urandom_range(0, 31));
			run_random(ITEMS_PER_SET);
		end
		// Back to the reset field, written explicitly this time.
		set_field(FIELD_BITS_RST, POLY_RST);
		run_random(ITEMS_PER_SET);
		wait_drained();

		$display("Mapped %0d forward and %0d inverse requests across %0d field settings,",
			n_forward, n_inverse, n_settings);
		$display("including degenerate widths, reducible moduli and stray input bits.");
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
